[hdl/pixel_point_op_chain_core_assert.svh]
// assertion macros for the pixel point operation chain core
`ifndef PIXEL_POINT_OP_CHAIN_CORE_ASSERT_SVH
`define PIXEL_POINT_OP_CHAIN_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define PPOC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define PPOC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ppoc_pkg.sv]
`default_nettype none
package ppoc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = FRAC_BITS + 16;
    localparam int SLOTS     = 4;
    localparam int MAX_OPS   = 4;
    localparam int STEPS     = 16;

    typedef logic signed [WORD_W-1:0] t_word;

    localparam t_word WMAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam t_word WMIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_ADD,
        OP_MUL,
        OP_ABS,
        OP_POW
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OP,
        ST_NORM,
        ST_LOG,
        ST_ELOG,
        ST_EXP,
        ST_SCALE,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        REG_OP_COUNT,
        REG_OP_KINDS,
        REG_OP_VALUE_0,
        REG_OP_VALUE_1,
        REG_OP_VALUE_2,
        REG_OP_VALUE_3
    } t_reg;

    typedef struct packed {
        logic [2:0]                   nops;
        logic [2*SLOTS-1:0]           kinds;
        logic [SLOTS-1:0][WORD_W-1:0] vals;
    } t_cfg;

    typedef logic [STEPS-1:0][31:0] t_roots;

    function automatic logic [63:0] f_isqrt(input logic [63:0] n);
        logic [63:0] nn;
        logic [63:0] r;
        logic [63:0] bitv;
        nn   = n;
        r    = 64'd0;
        bitv = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (bitv > nn) bitv = bitv >> 2;
        end
        for (int j = 0; j < 32; j++) begin
            if (bitv != 64'd0) begin
                if (nn >= r + bitv) begin
                    nn = nn - (r + bitv);
                    r  = (r >> 1) + bitv;
                end else begin
                    r = r >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return r;
    endfunction

    // successive square roots of 2.0 in q2.30, one per exp2 fraction bit
    function automatic t_roots f_roots();
        t_roots      tab;
        logic [63:0] r;
        r = 64'd1 << 31;
        for (int i = 0; i < STEPS; i++) begin
            r      = f_isqrt(r << 30);
            tab[i] = r[31:0];
        end
        return tab;
    endfunction

    localparam t_roots ROOTS = f_roots();

endpackage
`default_nettype wire

[hdl/ppoc_engine.sv]
`default_nettype none
module ppoc_engine import ppoc_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_pixel,
    output logic            o_done_valid,
    input  wire logic       i_done_ready,
    output t_word           o_w
);

    t_state              r_state, n_state;
    t_word               r_w, n_w;
    logic [2:0]          r_slot, n_slot;
    logic [31:0]         r_m, n_m;
    logic [4:0]          r_sh, n_sh;
    logic [3:0]          r_step, n_step;
    logic [15:0]         r_frac, n_frac;
    logic signed [37:0]  r_t, n_t;

    t_op                 kind;
    t_word               v;
    logic [31:0]         abs_w, abs_v;
    logic [31:0]         mul_a, mul_b;
    logic [63:0]         prod;
    logic [47:0]         mag;
    logic                mneg;
    logic signed [32:0]  sum;
    logic [31:0]         sq;
    logic signed [5:0]   lint;
    logic signed [21:0]  lg;
    logic [20:0]         lg_mag;
    logic                pneg;
    logic signed [53:0]  sprod;
    logic signed [21:0]  ni;
    logic signed [21:0]  dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_w    <= n_w;
        r_slot <= n_slot;
        r_m    <= n_m;
        r_sh   <= n_sh;
        r_step <= n_step;
        r_frac <= n_frac;
        r_t    <= n_t;
    end

    assign kind  = t_op'(i_cfg.kinds[{r_slot[1:0], 1'b0} +: 2]);
    assign v     = $signed(i_cfg.vals[r_slot[1:0]]);
    assign abs_w = r_w[WORD_W-1] ? (~r_w + 32'd1) : r_w;
    assign abs_v = v[WORD_W-1] ? (~v + 32'd1) : v;

    // log2 integer part is 14 minus the normalizing shift count
    assign lint   = 6'sd14 - $signed({1'b0, r_sh});
    assign lg     = {lint, r_frac};
    assign lg_mag = lg[21] ? 21'(-lg) : lg[20:0];

    // the shared multiplier
    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (r_state)
            ST_OP: begin
                mul_a = abs_w;
                mul_b = abs_v;
            end
            ST_LOG: begin
                mul_a = r_m;
                mul_b = r_m;
            end
            ST_ELOG: begin
                mul_a = abs_v;
                mul_b = {11'd0, lg_mag};
            end
            ST_EXP: begin
                mul_a = r_m;
                mul_b = ROOTS[r_step];
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign prod  = mul_a * mul_b;
    assign mag   = prod[63:16];
    assign mneg  = r_w[WORD_W-1] ^ v[WORD_W-1];
    assign sum   = {r_w[WORD_W-1], r_w} + {v[WORD_W-1], v};
    assign sq    = prod[61:30];
    assign pneg  = lg[21] ^ v[WORD_W-1];
    assign sprod = pneg ? -$signed({1'b0, prod[52:0]}) : $signed({1'b0, prod[52:0]});
    assign ni    = r_t[37:16];
    assign dsh   = 22'sd14 - ni;

    always_comb begin
        n_state      = r_state;
        n_w          = r_w;
        n_slot       = r_slot;
        n_m          = r_m;
        n_sh         = r_sh;
        n_step       = r_step;
        n_frac       = r_frac;
        n_t          = r_t;
        o_ready      = 1'b0;
        o_done_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_w     = {8'd0, i_pixel, 16'd0};
                    n_slot  = 3'd0;
                    n_state = ST_OP;
                end
            end
            ST_OP: begin
                if (r_slot >= i_cfg.nops) begin
                    n_state = ST_DONE;
                end else begin
                    n_slot = r_slot + 3'd1;
                    case (kind)
                        OP_ADD: begin
                            if (sum[32] != sum[31]) n_w = sum[32] ? WMIN : WMAX;
                            else n_w = sum[31:0];
                        end
                        OP_MUL: begin
                            if (mneg) n_w = (mag > 48'h8000_0000) ? WMIN : -$signed(mag[31:0]);
                            else n_w = (mag > 48'h7FFF_FFFF) ? WMAX : mag[31:0];
                        end
                        OP_ABS: begin
                            if (r_w == WMIN) n_w = WMAX;
                            else if (r_w[WORD_W-1]) n_w = -r_w;
                            else n_w = r_w;
                        end
                        OP_POW: begin
                            if (r_w[WORD_W-1] || r_w == '0) begin
                                n_w = '0;
                            end else begin
                                n_slot  = r_slot;
                                n_m     = r_w;
                                n_sh    = 5'd0;
                                n_state = ST_NORM;
                            end
                        end
                        default: n_w = r_w;
                    endcase
                end
            end
            ST_NORM: begin
                if (r_m[30]) begin
                    n_step  = 4'd0;
                    n_frac  = 16'd0;
                    n_state = ST_LOG;
                end else begin
                    n_m  = {r_m[30:0], 1'b0};
                    n_sh = r_sh + 5'd1;
                end
            end
            ST_LOG: begin
                // square, then renormalize when the mantissa reached 2.0
                if (sq[31]) begin
                    n_m    = {1'b0, sq[31:1]};
                    n_frac = {r_frac[14:0], 1'b1};
                end else begin
                    n_m    = sq;
                    n_frac = {r_frac[14:0], 1'b0};
                end
                n_step = r_step + 4'd1;
                if (r_step == 4'd15) n_state = ST_ELOG;
            end
            ST_ELOG: begin
                n_t     = sprod[53:16];
                n_m     = 32'd1 << 30;
                n_step  = 4'd0;
                n_state = ST_EXP;
            end
            ST_EXP: begin
                if (r_t[4'd15 - r_step]) n_m = sq;
                n_step = r_step + 4'd1;
                if (r_step == 4'd15) n_state = ST_SCALE;
            end
            ST_SCALE: begin
                if (ni > 22'sd14) n_w = WMAX;
                else if (ni == 22'sd14) n_w = r_m;
                else if (ni < -22'sd17) n_w = '0;
                else n_w = r_m >> dsh[4:0];
                n_slot  = r_slot + 3'd1;
                n_state = ST_OP;
            end
            ST_DONE: begin
                o_done_valid = 1'b1;
                if (i_done_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_w = r_w;

endmodule
`default_nettype wire

[hdl/pixel_point_op_chain_core.sv]
// pixel point operation chain
// one 8-bit intensity enters on the s_axis channel; up to four configured
// operations (add, multiply, absolute, power) run in slot order on a q16.16
// working value, then the value is rounded, clipped to 0..255 and leaves on
// the m_axis channel together with clip flags and saturating clip counters.
// configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the
// user must write it only while the block is idle (the block does not
// enforce this); register index follows op_count, op_kinds, op_value_0..3.
// multiplies run on one shared 32x32 multiplier under a sequencer: add,
// multiply and absolute take one step each; power runs one dispatch step,
// up to 30 normalizing shifts plus a check, 16 log2 squarings, one scaling
// multiply, 16 exp2 multiplies and one final shift. s_axis_tready is high
// only while the sequencer is idle, so a new item is taken only after the
// last one has been handed to the output register.
// the finished result sits in an output register; the next item can be
// taken while it waits, and a stalled receiver holds the sequencer at its end.
// reset clears configuration, counters and control state.
`default_nettype none
module pixel_point_op_chain_core import ppoc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // pixel_in
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // pixel_out, clipped_high, clipped_low, high_clip_total, low_clip_total, zero fill
    output logic [79:0]      m_axis_tdata
);

    `include "pixel_point_op_chain_core_assert.svh"

    logic [2:0]                   r_op_count;
    logic [2*SLOTS-1:0]           r_op_kinds;
    logic [SLOTS-1:0][WORD_W-1:0] r_op_vals;
    logic [31:0]                  r_high_cnt, n_high_cnt;
    logic [31:0]                  r_low_cnt, n_low_cnt;
    logic                         r_out_valid;
    logic [7:0]                   r_pix;
    logic                         r_hi, r_lo;

    t_cfg                         cfg;
    logic                         done_valid;
    logic                         done_ready;
    t_word                        w;
    logic signed [32:0]           s;
    logic                         hi, lo;
    logic [7:0]                   pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_count <= '0;
            r_op_kinds <= '0;
            r_op_vals  <= '0;
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_idx))
                REG_OP_COUNT:   r_op_count   <= i_cfg_data[2:0];
                REG_OP_KINDS:   r_op_kinds   <= i_cfg_data[7:0];
                REG_OP_VALUE_0: r_op_vals[0] <= i_cfg_data;
                REG_OP_VALUE_1: r_op_vals[1] <= i_cfg_data;
                REG_OP_VALUE_2: r_op_vals[2] <= i_cfg_data;
                REG_OP_VALUE_3: r_op_vals[3] <= i_cfg_data;
                default: r_op_count <= r_op_count;
            endcase
        end
    end

    always_comb begin
        cfg.nops  = (r_op_count > 3'(MAX_OPS)) ? 3'(MAX_OPS) : r_op_count;
        cfg.kinds = r_op_kinds;
        cfg.vals  = r_op_vals;
    end

    ppoc_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_pixel      (s_axis_tdata),
        .o_done_valid (done_valid),
        .i_done_ready (done_ready),
        .o_w          (w)
    );

    // add one half, truncate toward zero, clip
    assign s   = {w[WORD_W-1], w} + 33'sd32768;
    assign lo  = s < -33'sd65535;
    assign hi  = !s[32] && (s[31:24] != 8'd0);
    assign pix = hi ? 8'd255 : (s[32] ? 8'd0 : s[23:16]);

    assign done_ready = !r_out_valid || m_axis_tready;

    always_comb begin
        n_high_cnt = r_high_cnt;
        n_low_cnt  = r_low_cnt;
        if (hi && r_high_cnt != '1) n_high_cnt = r_high_cnt + 32'd1;
        if (lo && r_low_cnt != '1) n_low_cnt = r_low_cnt + 32'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_high_cnt  <= '0;
            r_low_cnt   <= '0;
        end else if (done_valid && done_ready) begin
            r_out_valid <= 1'b1;
            r_high_cnt  <= n_high_cnt;
            r_low_cnt   <= n_low_cnt;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (done_valid && done_ready) begin
            r_pix <= pix;
            r_hi  <= hi;
            r_lo  <= lo;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_low_cnt, r_high_cnt, r_lo, r_hi, r_pix};

    `PPOC_ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "sequencer still ready after taking an item")
    `PPOC_ASSERT_IMP(a_high_clip_pixel, i_clk, i_rst_n, r_out_valid && r_hi, r_pix == 8'd255 && !r_lo, "high clip with wrong pixel or both flags")
    `PPOC_ASSERT_IMP(a_high_cnt_step, i_clk, i_rst_n, $past(i_rst_n) && r_high_cnt != $past(r_high_cnt), r_high_cnt == $past(r_high_cnt) + 32'd1 && r_hi, "high clip counter moved by more than one")

endmodule
`default_nettype wire

[dv/tb_top.sv]
`default_nettype none
module tb_top;
    import ppoc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]  pix;
        logic        hi;
        logic        lo;
        logic [31:0] hi_tot;
        logic [31:0] lo_tot;
    } t_pix_res;

    // predictor of the operation chain plus queue of pending results
    class pixel_scoreboard;
        logic [2:0]       nops;
        logic [7:0]       kinds;
        logic signed [63:0] vals [4];
        logic [31:0]      hi_cnt, lo_cnt;
        t_pix_res         pending [$];
        int               errors;

        function new();
            nops = 0; kinds = 0; hi_cnt = 0; lo_cnt = 0; errors = 0;
            for (int i = 0; i < 4; i++) vals[i] = 0;
        endfunction

        function void write_reg(t_reg idx, logic [31:0] d);
            case (idx)
                REG_OP_COUNT: nops = d[2:0];
                REG_OP_KINDS: kinds = d[7:0];
                REG_OP_VALUE_0: vals[0] = $signed(d);
                REG_OP_VALUE_1: vals[1] = $signed(d);
                REG_OP_VALUE_2: vals[2] = $signed(d);
                REG_OP_VALUE_3: vals[3] = $signed(d);
                default: ;
            endcase
        endfunction

        function logic signed [63:0] clamp(logic signed [63:0] v);
            logic signed [63:0] mx, mn;
            mx = (64'sd1 <<< 31) - 1;
            mn = -mx - 1;
            if (v > mx) return mx;
            if (v < mn) return mn;
            return v;
        endfunction

        function logic signed [63:0] floor_shr(logic signed [63:0] p, int s);
            return p >>> s;
        endfunction

        function logic signed [63:0] mul(logic signed [63:0] w, logic signed [63:0] v);
            logic neg;
            logic [63:0] a, b, m;
            neg = (w < 0) != (v < 0);
            a = (w < 0) ? -w : w;
            b = (v < 0) ? -v : v;
            m = (a * b) >> 16;
            if (neg) return (m > 64'h8000_0000) ? -(64'sd1 <<< 31) : -$signed(m);
            return (m > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : $signed(m);
        endfunction

        function logic [63:0] sqrt64(logic [63:0] n);
            logic [63:0] r, b;
            r = 0; b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b); r = (r >> 1) + b;
                end else r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function logic signed [63:0] log2fx(logic signed [63:0] x);
            logic [63:0] m;
            int k;
            logic signed [63:0] frac;
            k = 0; frac = 0;
            for (int i = 0; i < 63; i++) if (x[i]) k = i;
            m = (k <= 30) ? (x << (30 - k)) : (x >> (k - 30));
            for (int i = 0; i < 16; i++) begin
                m = (m * m) >> 30;
                frac = frac << 1;
                if (m >= (64'd2 << 30)) begin
                    frac = frac | 1; m = m >> 1;
                end
            end
            return 64'(k - 16) * 65536 + frac;
        endfunction

        function logic signed [63:0] exp2fx(logic signed [63:0] t);
            logic signed [63:0] n, s;
            logic [63:0] f, acc, r;
            n = t >>> 16;
            f = t - n * 65536;
            acc = 64'd1 << 30; r = 64'd1 << 31;
            for (int i = 1; i <= 16; i++) begin
                r = sqrt64(r << 30);
                if (f[16-i]) acc = (acc * r) >> 30;
            end
            s = n - 14;
            if (30 + s >= 31) return 64'sh7FFF_FFFF;
            if (s >= 0) return $signed(acc << s);
            if (-s >= 32) return 64'sd0;
            return $signed(acc >> (-s));
        endfunction

        function void note_pixel(logic [7:0] px);
            logic signed [63:0] w, s, iv;
            logic [1:0] k;
            t_pix_res r;
            w = 64'(px) << 16;
            for (int i = 0; i < nops && i < 4; i++) begin
                k = kinds[2*i +: 2];
                case (t_op'(k))
                    OP_ADD: w = clamp(w + vals[i]);
                    OP_MUL: w = mul(w, vals[i]);
                    OP_ABS: w = (w < 0) ? clamp(-w) : w;
                    OP_POW: w = (w <= 0) ? 64'sd0 :
                        clamp(exp2fx(floor_shr(vals[i] * log2fx(w), 16)));
                    default: ;
                endcase
            end
            s = w + 32768;
            iv = (s >= 0) ? (s >>> 16) : -((-s) >>> 16);
            r = '0;
            if (iv > 255) begin
                r.pix = 8'd255; r.hi = 1'b1;
                if (hi_cnt != 32'hFFFF_FFFF) hi_cnt++;
            end else if (iv < 0) begin
                r.lo = 1'b1;
                if (lo_cnt != 32'hFFFF_FFFF) lo_cnt++;
            end else r.pix = iv[7:0];
            r.hi_tot = hi_cnt; r.lo_tot = lo_cnt;
            pending.push_back(r);
        endfunction

        function void check_result(logic [79:0] d);
            t_pix_res e;
            if (pending.size() == 0) begin
                $error("result with no pending pixel: %h", d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[7:0] != e.pix) begin
                $error("pixel_out exp %0d got %0d", e.pix, d[7:0]); errors++;
            end
            if (d[8] != e.hi) begin
                $error("clipped_high exp %0d got %0d", e.hi, d[8]); errors++;
            end
            if (d[9] != e.lo) begin
                $error("clipped_low exp %0d got %0d", e.lo, d[9]); errors++;
            end
            if (d[41:10] != e.hi_tot) begin
                $error("high_clip_total exp %0d got %0d", e.hi_tot, d[41:10]); errors++;
            end
            if (d[73:42] != e.lo_tot) begin
                $error("low_clip_total exp %0d got %0d", e.lo_tot, d[73:42]); errors++;
            end
            if (d[79:74] != 0) begin
                $error("zero fill exp 0 got %0h", d[79:74]); errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_idx = 0;
    logic [31:0] i_cfg_data = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 0;   // pixel_in
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    // pixel_out, clipped_high, clipped_low, high_clip_total, low_clip_total, zero fill
    logic [79:0] m_axis_tdata;

    pixel_scoreboard sb = new();
    longint cycles = 0;
    bit     stall_rx = 1;
    int     rx_hold = 0;

    pixel_point_op_chain_core dut (.*);

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 3_000_000) begin
            $display("pixel_point_op_chain_core verification failed");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    function int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    endfunction

    // receiver: random stall, occasionally long
    always @(negedge i_clk) begin
        if (!stall_rx) begin
            m_axis_tready <= 1;
        end else if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 0;
        end else if ($urandom_range(0, 3) == 0) begin
            rx_hold = gap_len();
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= 1;
        end
    end

    task automatic cfg_write(t_reg idx, logic [31:0] d);
        @(negedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= d;
        @(negedge i_clk);
        i_cfg_we <= 0;
        sb.write_reg(idx, d);
    endtask

    task automatic send_pixel(logic [7:0] px, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        @(negedge i_clk);
        repeat (g) @(negedge i_clk);
        s_axis_tvalid <= 1; s_axis_tdata <= px;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_pixel(px);
        @(negedge i_clk);
        s_axis_tvalid <= 0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic set_chain(logic [2:0] n, logic [7:0] k, logic [31:0] v0,
                             logic [31:0] v1, logic [31:0] v2, logic [31:0] v3);
        cfg_write(REG_OP_COUNT, 32'(n));
        cfg_write(REG_OP_KINDS, 32'(k));
        cfg_write(REG_OP_VALUE_0, v0);
        cfg_write(REG_OP_VALUE_1, v1);
        cfg_write(REG_OP_VALUE_2, v2);
        cfg_write(REG_OP_VALUE_3, v3);
    endtask

    function logic [31:0] rand_val();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 32'h0004_0000);              // 0..4.0
            2: return -$urandom_range(0, 32'h0040_0000);
            3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(32'h0000_4000, 32'h0003_0000);
        endcase
    endfunction

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // default: no operations, pass-through
        send_pixel(8'd0, 0);
        send_pixel(8'd255, 0);
        send_pixel(8'd128, 0);
        drain();
        // add saturating high, then power of nonpositive base
        set_chain(3'd1, {6'd0, OP_ADD}, 32'h7FFF_FFFF, 0, 0, 0);
        send_pixel(8'd255, 0); send_pixel(8'd1, 0);
        drain();
        set_chain(3'd2, {4'd0, OP_POW, OP_ADD}, 32'h8000_0000, 32'h0002_0000, 0, 0);
        send_pixel(8'd255, 0); send_pixel(8'd0, 0);
        drain();
        // absolute of most negative value
        set_chain(3'd2, {4'd0, OP_ABS, OP_ADD}, 32'h8000_0000, 0, 0, 0);
        send_pixel(8'd0, 0); send_pixel(8'd200, 0);
        drain();
        // rounding near -0.5: (-1.5,-0.5] gives 0, no low clip
        set_chain(3'd1, {6'd0, OP_ADD}, 32'hFFFF_0000 - 32'h8000, 0, 0, 0);
        send_pixel(8'd0, 0); send_pixel(8'd1, 0);
        drain();
        cfg_write(REG_OP_VALUE_0, 32'hFFFE_8001);
        send_pixel(8'd0, 0);
        drain();
        // multiply negative, power with negative exponent, count above slots
        set_chain(3'd7, {OP_POW, OP_MUL, OP_ABS, OP_MUL}, 32'hFFFF_8000,
                  32'h0001_8000, 32'h0000_8000, 32'hFFFF_0000);
        send_pixel(8'd255, 0); send_pixel(8'd7, 0); send_pixel(8'd1, 0);
        drain();
        set_chain(3'd4, {4{OP_POW}}, 32'h0002_0000, 32'h0000_8000,
                  32'h7FFF_FFFF, 32'h8000_0000);
        send_pixel(8'd16, 0); send_pixel(8'd255, 0);
        drain();

        for (int ph = 0; ph < 28; ph++) begin
            int n;
            stall_rx = (ph % 5) != 2;
            set_chain(3'($urandom_range(0, 7)), 8'($urandom()), rand_val(), rand_val(),
                      rand_val(), rand_val());
            n = 50;
            for (int j = 0; j < n; j++) begin
                send_pixel(8'($urandom_range(0, 255)), (ph % 4) != 1);
                // sender waits for all results once in a while
                if (j == 25 && ph % 3 == 0)
                    while (sb.pending.size() != 0) @(posedge i_clk);
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("pixel_point_op_chain_core verification clean");
        else
            $display("pixel_point_op_chain_core verification failed");
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
+incdir+hdl
hdl/ppoc_pkg.sv
hdl/ppoc_engine.sv
hdl/pixel_point_op_chain_core.sv
dv/tb_top.sv
